// ===== rtl/core/lspf_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lspf_pkg
// shared types and constants of the least-squares polynomial fit block
// ----------------------------------------------------------------------------
package lspf_pkg;

    // point limit per data set and width of the point counter
    localparam int MAX_POINTS  = 1024;
    localparam int CNT_W       = $clog2(MAX_POINTS + 1);

    // magnitude width of the exact determinant arithmetic
    localparam int MW          = 232;

    // depth of the queue between accumulator and solver
    localparam int QUEUE_DEPTH = 2;

    // column code meaning no column replaced (plain normal-matrix determinant)
    localparam logic [1:0] COL_NONE = 2'd3;

    typedef struct packed {
        logic signed [11:0] x_value;
        logic signed [15:0] y_value;
        logic               last_point;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] coef_const;
        logic signed [31:0] coef_linear;
        logic signed [31:0] coef_square;
        logic               singular;
        logic               saturated;
    } t_out_word;

    // finished data set handed from accumulator to solver
    typedef struct packed {
        logic [CNT_W-1:0] cnt;
        logic [63:0]      p1;
        logic [63:0]      p2;
        logic [63:0]      p3;
        logic [63:0]      p4;
        logic [63:0]      m0;
        logic [63:0]      m1;
        logic [63:0]      m2;
        logic             quad;
        logic             dropped;
    } t_sums_word;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TERM,
        ST_LDB,
        ST_MUL,
        ST_MULEND,
        ST_DET,
        ST_OVF,
        ST_DIV,
        ST_SAT,
        ST_OUT
    } t_solve_state;

endpackage
`default_nettype wire

// ===== rtl/core/lspf_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lspf_front
// power pipeline and running sums, one point per cycle unless a final point waits on a full set queue
// ----------------------------------------------------------------------------
module lspf_front import lspf_pkg::*; (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_push,
    input  t_in_word   i_in_word,
    output logic       o_full,
    input  wire        i_quad,
    input  wire        i_q_full,
    output logic       o_q_push,
    output t_sums_word o_q_data
);

    logic               r1_v, r1_last;
    logic signed [11:0] r1_x;
    logic signed [15:0] r1_y;
    logic signed [23:0] r1_x2;
    logic signed [27:0] r1_xy;

    logic               r2_v, r2_last;
    logic signed [11:0] r2_x;
    logic signed [15:0] r2_y;
    logic signed [23:0] r2_x2;
    logic signed [27:0] r2_xy;
    logic signed [35:0] r2_x3;
    logic signed [47:0] r2_x4;
    logic signed [39:0] r2_x2y;

    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [63:0]      r_p1, r_p2, r_p3, r_p4, r_m0, r_m1, r_m2;
    logic [63:0]      n_p1, n_p2, n_p3, n_p4, n_m0, n_m1, n_m2;
    logic             r_drop, n_drop;

    logic w_en, w_keep, w_last;

    assign w_last   = r2_v && r2_last;
    assign w_en     = !(w_last && i_q_full);
    assign o_full   = !w_en;
    assign o_q_push = w_last && !i_q_full;
    assign w_keep   = r2_v && (r_cnt < CNT_W'(MAX_POINTS));

    always_comb begin
        n_cnt  = r_cnt;
        n_p1   = r_p1;
        n_p2   = r_p2;
        n_p3   = r_p3;
        n_p4   = r_p4;
        n_m0   = r_m0;
        n_m1   = r_m1;
        n_m2   = r_m2;
        n_drop = r_drop || (r2_v && !w_keep);
        if (w_keep) begin
            n_cnt = r_cnt + 1'b1;
            n_p1  = r_p1 + 64'(r2_x);
            n_p2  = r_p2 + 64'(r2_x2);
            n_p3  = r_p3 + 64'(r2_x3);
            n_p4  = r_p4 + 64'(r2_x4);
            n_m0  = r_m0 + 64'(r2_y);
            n_m1  = r_m1 + 64'(r2_xy);
            n_m2  = r_m2 + 64'(r2_x2y);
        end
    end

    always_comb begin
        o_q_data.cnt     = n_cnt;
        o_q_data.p1      = n_p1;
        o_q_data.p2      = n_p2;
        o_q_data.p3      = n_p3;
        o_q_data.p4      = n_p4;
        o_q_data.m0      = n_m0;
        o_q_data.m1      = n_m1;
        o_q_data.m2      = n_m2;
        o_q_data.quad    = i_quad;
        o_q_data.dropped = n_drop;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
        end else if (w_en) begin
            r1_v <= i_push;
            r2_v <= r1_v;
        end
    end

    // payload stages, one multiply level each
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_last <= i_in_word.last_point;
            r1_x    <= i_in_word.x_value;
            r1_y    <= i_in_word.y_value;
            r1_x2   <= i_in_word.x_value * i_in_word.x_value;
            r1_xy   <= i_in_word.x_value * i_in_word.y_value;
            r2_last <= r1_last;
            r2_x    <= r1_x;
            r2_y    <= r1_y;
            r2_x2   <= r1_x2;
            r2_xy   <= r1_xy;
            r2_x3   <= r1_x2 * r1_x;
            r2_x4   <= r1_x2 * r1_x2;
            r2_x2y  <= r1_x2 * r1_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (w_en && w_last)) begin
            r_cnt  <= '0;
            r_p1   <= '0;
            r_p2   <= '0;
            r_p3   <= '0;
            r_p4   <= '0;
            r_m0   <= '0;
            r_m1   <= '0;
            r_m2   <= '0;
            r_drop <= 1'b0;
        end else if (w_en) begin
            r_cnt  <= n_cnt;
            r_p1   <= n_p1;
            r_p2   <= n_p2;
            r_p3   <= n_p3;
            r_p4   <= n_p4;
            r_m0   <= n_m0;
            r_m1   <= n_m1;
            r_m2   <= n_m2;
            r_drop <= n_drop;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/lspf_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lspf_queue
// short fifo of finished data sets between accumulator and solver
// ----------------------------------------------------------------------------
module lspf_queue import lspf_pkg::*; (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_push,
    input  t_sums_word i_data,
    output logic       o_full,
    input  wire        i_pop,
    output logic       o_empty,
    output t_sums_word o_data
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_sums_word    r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;
    logic          w_push, w_pop;

    assign o_full  = (r_cnt == CW'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + CW'(w_push) - CW'(w_pop);
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/lspf_solver.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lspf_solver
// exact cramer solve with bit-serial multiply and restoring divide
// ----------------------------------------------------------------------------
module lspf_solver import lspf_pkg::*; (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_q_empty,
    input  t_sums_word i_q_data,
    output logic       o_q_pop,
    output logic       o_empty,
    input  wire        i_pop,
    output t_out_word  o_out_word
);

    // column of a row under permutation perm
    function automatic logic [1:0] perm_col(input logic quad, input logic [2:0] perm,
                                            input logic [1:0] row);
        logic [5:0] cols;
        begin
            if (quad) begin
                case (perm)
                    3'd0:    cols = {2'd2, 2'd1, 2'd0};
                    3'd1:    cols = {2'd0, 2'd2, 2'd1};
                    3'd2:    cols = {2'd1, 2'd0, 2'd2};
                    3'd3:    cols = {2'd1, 2'd2, 2'd0};
                    3'd4:    cols = {2'd2, 2'd0, 2'd1};
                    default: cols = {2'd0, 2'd1, 2'd2};
                endcase
            end else begin
                cols = (perm == 3'd0) ? {2'd2, 2'd1, 2'd0} : {2'd2, 2'd0, 2'd1};
            end
            perm_col = cols[2*row +: 2];
        end
    endfunction

    function automatic logic perm_neg(input logic quad, input logic [2:0] perm);
        perm_neg = quad ? (perm >= 3'd3) : (perm == 3'd1);
    endfunction

    t_solve_state r_state, n_state;

    logic signed [63:0] r_e [8];
    logic               r_quad;
    logic [1:0]         r_k, n_k;
    logic [2:0]         r_perm, n_perm;
    logic               r_phase, n_phase;
    logic               r_sign, n_sign;
    logic [MW-1:0]      r_a, n_a;
    logic [63:0]        r_b, n_b;
    logic [5:0]         r_bit, n_bit;
    logic [MW-1:0]      r_prod, n_prod;
    logic signed [MW:0] r_acc, n_acc;
    logic [MW-1:0]      r_den, n_den;
    logic               r_den_neg, n_den_neg;
    logic [MW-1:0]      r_rem, n_rem;
    logic [MW-1:0]      r_dsh, n_dsh;
    logic               r_neg, n_neg;
    logic [31:0]        r_q, n_q;
    logic [31:0]        r_coef [3];
    logic [31:0]        n_coef [3];
    logic               r_sing, n_sing;
    logic               r_clip, n_clip;
    logic               r_out_valid, n_out_valid;
    logic               w_load, w_emit;

    logic [1:0]         w_row, w_col;
    logic [2:0]         w_idx;
    logic signed [63:0] w_e;
    logic [63:0]        w_e_mag;
    logic [MW-1:0]      w_acc_mag;
    logic [4:0]         w_shift;
    logic [31:0]        w_limit, w_qv;
    logic [2:0]         w_last_perm;
    logic [1:0]         w_last_k;

    // single read port into the entry registers
    always_comb begin
        w_row   = (r_state == ST_TERM) ? 2'd0 : (r_phase ? 2'd2 : 2'd1);
        w_col   = perm_col(r_quad, r_perm, w_row);
        w_idx   = (w_col == r_k) ? 3'(3'd5 + 3'(w_row)) : 3'(3'(w_row) + 3'(w_col));
        w_e     = r_e[w_idx];
        w_e_mag = w_e[63] ? 64'(-w_e) : 64'(w_e);
    end

    assign w_acc_mag   = r_acc[MW] ? MW'(-r_acc) : r_acc[MW-1:0];
    assign w_shift     = {r_k, 3'b000} + 5'd8;
    assign w_limit     = r_neg ? 32'h8000_0000 : 32'h7fff_ffff;
    assign w_qv        = (r_q > w_limit) ? w_limit : r_q;
    assign w_last_perm = r_quad ? 3'd5 : 3'd1;
    assign w_last_k    = r_quad ? 2'd2 : 2'd1;
    assign w_load      = (r_state == ST_IDLE) && !i_q_empty;
    assign w_emit      = (r_state == ST_OUT) && (!r_out_valid || i_pop);
    assign o_q_pop     = w_load;
    assign o_empty     = !r_out_valid;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (!i_q_empty) n_state = ST_TERM;
            ST_TERM:   n_state = ST_LDB;
            ST_LDB:    n_state = ST_MUL;
            ST_MUL:    if (r_bit == '0) n_state = ST_MULEND;
            ST_MULEND: begin
                if (r_quad && !r_phase) begin
                    n_state = ST_LDB;
                end else if (r_perm == w_last_perm) begin
                    n_state = ST_DET;
                end else begin
                    n_state = ST_TERM;
                end
            end
            ST_DET: begin
                if (r_k != COL_NONE) begin
                    n_state = ST_OVF;
                end else if (r_acc == '0) begin
                    n_state = ST_OUT;
                end else begin
                    n_state = ST_TERM;
                end
            end
            ST_OVF: begin
                if ({32'b0, r_rem} >= {r_den, 32'b0}) begin
                    n_state = ST_SAT;
                end else begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV:    if (r_bit == '0) n_state = ST_SAT;
            ST_SAT:    n_state = (r_k == w_last_k) ? ST_OUT : ST_TERM;
            ST_OUT:    if (w_emit) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // datapath
    always_comb begin
        n_k         = r_k;
        n_perm      = r_perm;
        n_phase     = r_phase;
        n_sign      = r_sign;
        n_a         = r_a;
        n_b         = r_b;
        n_bit       = r_bit;
        n_prod      = r_prod;
        n_acc       = r_acc;
        n_den       = r_den;
        n_den_neg   = r_den_neg;
        n_rem       = r_rem;
        n_dsh       = r_dsh;
        n_neg       = r_neg;
        n_q         = r_q;
        n_coef      = r_coef;
        n_sing      = r_sing;
        n_clip      = r_clip;
        n_out_valid = r_out_valid && !i_pop;
        case (r_state)
            ST_IDLE: begin
                if (!i_q_empty) begin
                    n_k    = COL_NONE;
                    n_perm = '0;
                    n_acc  = '0;
                    n_sing = 1'b0;
                    n_clip = i_q_data.dropped;
                    n_coef = '{default: '0};
                end
            end
            ST_TERM: begin
                n_a     = MW'(w_e_mag);
                n_sign  = w_e[63] ^ perm_neg(r_quad, r_perm);
                n_phase = 1'b0;
            end
            ST_LDB: begin
                n_b    = w_e_mag;
                n_sign = r_sign ^ w_e[63];
                n_prod = '0;
                n_bit  = 6'd63;
            end
            ST_MUL: begin
                n_prod = (r_prod << 1) + (r_b[r_bit] ? r_a : '0);
                n_bit  = r_bit - 1'b1;
            end
            ST_MULEND: begin
                if (r_quad && !r_phase) begin
                    n_a     = r_prod;
                    n_phase = 1'b1;
                end else begin
                    n_acc  = r_sign ? r_acc - $signed({1'b0, r_prod})
                                    : r_acc + $signed({1'b0, r_prod});
                    n_perm = r_perm + 1'b1;
                end
            end
            ST_DET: begin
                if (r_k == COL_NONE) begin
                    if (r_acc == '0) begin
                        n_sing = 1'b1;
                    end else begin
                        n_den     = w_acc_mag;
                        n_den_neg = r_acc[MW];
                        n_k       = '0;
                        n_acc     = '0;
                        n_perm    = '0;
                    end
                end else begin
                    n_rem = w_acc_mag << w_shift;
                    n_neg = r_acc[MW] != r_den_neg;
                end
            end
            ST_OVF: begin
                if ({32'b0, r_rem} >= {r_den, 32'b0}) begin
                    n_q    = w_limit;
                    n_clip = 1'b1;
                end else begin
                    n_dsh = r_den << 31;
                    n_q   = '0;
                    n_bit = 6'd31;
                end
            end
            ST_DIV: begin
                if (r_rem >= r_dsh) begin
                    n_rem             = r_rem - r_dsh;
                    n_q[r_bit[4:0]]   = 1'b1;
                end
                n_dsh = r_dsh >> 1;
                n_bit = r_bit - 1'b1;
            end
            ST_SAT: begin
                if (r_q > w_limit) begin
                    n_clip = 1'b1;
                end
                n_coef[r_k] = r_neg ? 32'(-w_qv) : w_qv;
                n_k         = r_k + 1'b1;
                n_acc       = '0;
                n_perm      = '0;
            end
            ST_OUT: begin
                if (w_emit) begin
                    n_out_valid = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k       <= n_k;
        r_perm    <= n_perm;
        r_phase   <= n_phase;
        r_sign    <= n_sign;
        r_a       <= n_a;
        r_b       <= n_b;
        r_bit     <= n_bit;
        r_prod    <= n_prod;
        r_acc     <= n_acc;
        r_den     <= n_den;
        r_den_neg <= n_den_neg;
        r_rem     <= n_rem;
        r_dsh     <= n_dsh;
        r_neg     <= n_neg;
        r_q       <= n_q;
        r_coef    <= n_coef;
        r_sing    <= n_sing;
        r_clip    <= n_clip;
        if (w_load) begin
            r_e[0] <= 64'(i_q_data.cnt);
            r_e[1] <= i_q_data.p1;
            r_e[2] <= i_q_data.p2;
            r_e[3] <= i_q_data.p3;
            r_e[4] <= i_q_data.p4;
            r_e[5] <= i_q_data.m0;
            r_e[6] <= i_q_data.m1;
            r_e[7] <= i_q_data.m2;
            r_quad <= i_q_data.quad;
        end
        if (w_emit) begin
            o_out_word.coef_const  <= r_coef[0];
            o_out_word.coef_linear <= r_coef[1];
            o_out_word.coef_square <= r_coef[2];
            o_out_word.singular    <= r_sing;
            o_out_word.saturated   <= r_clip;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/least_squares_poly_fit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// least_squares_poly_fit
// streaming least-squares line or parabola fit with exact integer solve
// ----------------------------------------------------------------------------
//  channel   direction  handshake               word
//  points    in         push / full             t_in_word (x, y, last flag)
//  results   out        empty / pop             t_out_word (coefs q24.8/q16.16/q8.24, flags)
//  degree    in         i_cfg_we / i_cfg_wdata  fit degree, 1 line, 2 parabola
//
//  points enter at one per cycle unless full is high, via the power pipeline
//  multiplies are bit-serial: a determinant term takes one product for a
//    line and two for a parabola, 2 or 6 terms per determinant, 3 or 4
//    determinants, then a restoring divide per coefficient
//  sync reset clears sums, the set queue and the solver; degree resets to 1
//  full rises only while a final point waits on a full set queue;
//    the solver waits on a held result before emitting the next
// ----------------------------------------------------------------------------
module least_squares_poly_fit import lspf_pkg::*; (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        push,
    output logic       full,
    input  t_in_word   i_in_word,
    output logic       empty,
    input  wire        pop,
    output t_out_word  o_out_word,
    input  wire        i_cfg_we,
    input  wire [1:0]  i_cfg_wdata
);

    logic [1:0] r_fit_degree;
    logic       w_q_push, w_q_full, w_q_pop, w_q_empty;
    t_sums_word w_q_in, w_q_out;

    // degree 0 acts as line, 3 as parabola
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fit_degree <= 2'd1;
        end else if (i_cfg_we) begin
            r_fit_degree <= i_cfg_wdata;
        end
    end

    // front: powers and running sums
    lspf_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_in_word (i_in_word),
        .o_full    (full),
        .i_quad    (r_fit_degree[1]),
        .i_q_full  (w_q_full),
        .o_q_push  (w_q_push),
        .o_q_data  (w_q_in)
    );

    // finished data sets waiting for the solver
    lspf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_data  (w_q_in),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_empty (w_q_empty),
        .o_data  (w_q_out)
    );

    // back: determinants, divides, saturation
    lspf_solver u_solver (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_empty  (w_q_empty),
        .i_q_data   (w_q_out),
        .o_q_pop    (w_q_pop),
        .o_empty    (empty),
        .i_pop      (pop),
        .o_out_word (o_out_word)
    );

endmodule
`default_nettype wire
